@@ rtl/bpa_pkg.sv @@
// Shared constants, types and helper functions of the buddy page allocator.
`default_nettype none
package bpa_pkg;

  localparam int MAX_ORDER       = 10;
  localparam int PAGE_BYTES_LOG2 = 12;
  localparam int RECORD_SLOTS    = 64;
  localparam int TOTAL_PAGES     = 1024;

  localparam int BYTES_W = 23;
  localparam int PAGE_W  = $clog2(TOTAL_PAGES);
  localparam int ORD_W   = 4;
  localparam int ST_W    = 3;
  localparam int NORD    = MAX_ORDER + 1;
  localparam int CNT_W   = PAGE_W + 1;
  localparam int REC_AW  = $clog2(RECORD_SLOTS);
  localparam int REC_CW  = REC_AW + 1;
  localparam int FL_AW   = ORD_W + PAGE_W;
  localparam int FL_DEPTH = NORD * TOTAL_PAGES;

  localparam logic [ST_W-1:0] ST_OK         = 3'd0;
  localparam logic [ST_W-1:0] ST_TOO_LARGE  = 3'd1;
  localparam logic [ST_W-1:0] ST_NO_MEMORY  = 3'd2;
  localparam logic [ST_W-1:0] ST_TABLE_FULL = 3'd3;
  localparam logic [ST_W-1:0] ST_NOT_FOUND  = 3'd4;

  typedef struct packed {
    logic [PAGE_W-1:0] start;
    logic [ORD_W-1:0]  order;
  } rec_t;

  // Smallest order whose block holds the byte count; a result above
  // MAX_ORDER means the request is too large.
  function automatic logic [ORD_W:0] order_of_bytes(input logic [BYTES_W-1:0] bytes);
    logic [BYTES_W-1:0] m;
    logic [ORD_W:0]     len;
    logic [ORD_W:0]     o;
    m   = bytes - BYTES_W'(1);
    len = '0;
    for (int b = 0; b < BYTES_W; b++) begin
      if (m[b]) len = (ORD_W+1)'(b + 1);
    end
    if (bytes <= BYTES_W'(1)) o = '0;
    else if (len > (ORD_W+1)'(PAGE_BYTES_LOG2)) o = len - (ORD_W+1)'(PAGE_BYTES_LOG2);
    else o = '0;
    return o;
  endfunction

endpackage
`default_nettype wire

@@ rtl/bpa_flist_ram.sv @@
// Free-list storage: one ring of start pages per order, registered read.
`default_nettype none
module bpa_flist_ram (
  input  wire logic                      clk,
  input  wire logic                      we,
  input  wire logic [bpa_pkg::FL_AW-1:0] waddr,
  input  wire logic [bpa_pkg::PAGE_W-1:0] wdata,
  input  wire logic [bpa_pkg::FL_AW-1:0] raddr,
  output logic      [bpa_pkg::PAGE_W-1:0] rdata
);
  logic [bpa_pkg::PAGE_W-1:0] mem [bpa_pkg::FL_DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

@@ rtl/bpa_rec_ram.sv @@
// Allocation record table: (start, order) pairs, registered read.
`default_nettype none
module bpa_rec_ram (
  input  wire logic                       clk,
  input  wire logic                       we,
  input  wire logic [bpa_pkg::REC_AW-1:0] waddr,
  input  wire bpa_pkg::rec_t              wdata,
  input  wire logic [bpa_pkg::REC_AW-1:0] raddr,
  output bpa_pkg::rec_t                   rdata
);
  bpa_pkg::rec_t mem [bpa_pkg::RECORD_SLOTS];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

@@ rtl/buddy_page_allocator_core.sv @@
// Top level of the buddy page allocator: request sequencer around two memories.
`default_nettype none
// The block manages 1024 pages as buddy blocks of order 0 to 10 and serves one
// request at a time. An allocate request decodes the size, pops a free block
// and splits it one level at a time; a free request scans the records (up to
// 64) one by one and then, for each merge level, scans the free-list entries
// of that order one by one. The record memory and the free-list memory each
// have one read port, so their scans read one entry at a time. The
// free lists are rings kept per order in a single memory with a head pointer
// and a count in flip-flops, so popping the oldest entry is a pointer step.
// The result goes to an output register, so the next request is accepted while
// the previous result still waits to be taken. No clearing pass is needed
// after reset: only entries below each fill count are ever read, and the one
// initial entry, page 0 in the top-order list, is written while reset is held.
module buddy_page_allocator_core (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic                         in_func,
  input  wire logic [bpa_pkg::BYTES_W-1:0]  in_request_bytes,
  input  wire logic [bpa_pkg::PAGE_W-1:0]   in_free_start_page,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic      [bpa_pkg::ST_W-1:0]     out_status,
  output logic      [bpa_pkg::PAGE_W-1:0]   out_start_page,
  output logic      [bpa_pkg::ORD_W-1:0]    out_block_order
);
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DEC   = 4'd1;
  localparam logic [3:0] S_POP   = 4'd2;
  localparam logic [3:0] S_SPLIT = 4'd3;
  localparam logic [3:0] S_RSCAN = 4'd4;
  localparam logic [3:0] S_RMOVE = 4'd5;
  localparam logic [3:0] S_MCHK  = 4'd6;
  localparam logic [3:0] S_MSCAN = 4'd7;
  localparam logic [3:0] S_MREPL = 4'd8;
  localparam logic [3:0] S_RESP  = 4'd9;

  localparam int PW = bpa_pkg::PAGE_W;
  localparam int OW = bpa_pkg::ORD_W;
  localparam int CW = bpa_pkg::CNT_W;
  localparam int RA = bpa_pkg::REC_AW;
  localparam int RC = bpa_pkg::REC_CW;

  logic [3:0]   state_r, state_nxt;
  logic         func_r, func_nxt;
  logic [bpa_pkg::BYTES_W-1:0] bytes_r, bytes_nxt;
  logic [PW-1:0] fpage_r, fpage_nxt;
  logic [OW-1:0] want_r, want_nxt;
  logic [OW-1:0] k_r, k_nxt;
  logic [PW-1:0] page_r, page_nxt;
  logic [OW-1:0] ord_r, ord_nxt;
  logic [PW-1:0] s_r, s_nxt;
  logic [RA-1:0] i_r, i_nxt;
  logic [PW-1:0] j_r, j_nxt;
  logic [RC-1:0] rec_cnt_r, rec_cnt_nxt;
  logic [CW-1:0] fl_cnt_r  [bpa_pkg::NORD];
  logic [CW-1:0] fl_cnt_nxt[bpa_pkg::NORD];
  logic [PW-1:0] fl_head_r  [bpa_pkg::NORD];
  logic [PW-1:0] fl_head_nxt[bpa_pkg::NORD];
  logic [bpa_pkg::ST_W-1:0] res_st_r, res_st_nxt;
  logic [PW-1:0] res_page_r, res_page_nxt;
  logic [OW-1:0] res_ord_r, res_ord_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [bpa_pkg::ST_W-1:0] out_st_r, out_st_nxt;
  logic [PW-1:0] out_page_r, out_page_nxt;
  logic [OW-1:0] out_ord_r, out_ord_nxt;

  logic              fl_we;
  logic [bpa_pkg::FL_AW-1:0] fl_waddr, fl_raddr;
  logic [PW-1:0]     fl_wdata, fl_rdata;
  logic              rec_we;
  logic [RA-1:0]     rec_waddr, rec_raddr;
  bpa_pkg::rec_t     rec_wdata, rec_rdata;

  logic [OW:0]   want_w;
  logic          k_found;
  logic [OW-1:0] k_first;
  logic [OW-1:0] kd;
  logic [PW-1:0] buddy;
  logic          out_load;

  bpa_flist_ram u_flist (
    .clk(clk), .we(fl_we), .waddr(fl_waddr), .wdata(fl_wdata),
    .raddr(fl_raddr), .rdata(fl_rdata)
  );

  bpa_rec_ram u_rec (
    .clk(clk), .we(rec_we), .waddr(rec_waddr), .wdata(rec_wdata),
    .raddr(rec_raddr), .rdata(rec_rdata)
  );

  assign in_stall        = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_status      = out_st_r;
  assign out_start_page  = out_page_r;
  assign out_block_order = out_ord_r;

  assign want_w = bpa_pkg::order_of_bytes(bytes_r);
  assign kd     = k_r - OW'(1);
  assign buddy  = s_r ^ (PW'(1) << ord_r);

  // Lowest order at or above the wanted order that has a free block.
  always_comb begin
    k_found = 1'b0;
    k_first = '0;
    for (int o = 0; o < bpa_pkg::NORD; o++) begin
      if (!k_found && (OW+1)'(o) >= want_w && fl_cnt_r[o] != '0) begin
        k_found = 1'b1;
        k_first = OW'(o);
      end
    end
  end

  always_comb begin
    state_nxt   = state_r;
    func_nxt    = func_r;
    bytes_nxt   = bytes_r;
    fpage_nxt   = fpage_r;
    want_nxt    = want_r;
    k_nxt       = k_r;
    page_nxt    = page_r;
    ord_nxt     = ord_r;
    s_nxt       = s_r;
    i_nxt       = i_r;
    j_nxt       = j_r;
    rec_cnt_nxt = rec_cnt_r;
    fl_cnt_nxt  = fl_cnt_r;
    fl_head_nxt = fl_head_r;
    res_st_nxt  = res_st_r;
    res_page_nxt = res_page_r;
    res_ord_nxt = res_ord_r;
    fl_we     = 1'b0;
    fl_waddr  = '0;
    fl_wdata  = '0;
    fl_raddr  = '0;
    rec_we    = 1'b0;
    rec_waddr = '0;
    rec_wdata = '0;
    rec_raddr = '0;
    out_load  = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          func_nxt  = in_func;
          bytes_nxt = in_request_bytes;
          fpage_nxt = in_free_start_page;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        res_page_nxt = '0;
        res_ord_nxt  = '0;
        state_nxt    = S_RESP;
        if (!func_r) begin
          if (want_w > (OW+1)'(bpa_pkg::MAX_ORDER)) begin
            res_st_nxt = bpa_pkg::ST_TOO_LARGE;
          end else if (rec_cnt_r >= RC'(bpa_pkg::RECORD_SLOTS)) begin
            res_st_nxt = bpa_pkg::ST_TABLE_FULL;
          end else if (!k_found) begin
            res_st_nxt = bpa_pkg::ST_NO_MEMORY;
          end else begin
            want_nxt  = want_w[OW-1:0];
            k_nxt     = k_first;
            fl_raddr  = {k_first, fl_head_r[k_first]};
            state_nxt = S_POP;
          end
        end else begin
          if (rec_cnt_r == '0) begin
            res_st_nxt = bpa_pkg::ST_NOT_FOUND;
          end else begin
            i_nxt     = '0;
            rec_raddr = '0;
            state_nxt = S_RSCAN;
          end
        end
      end
      S_POP: begin
        page_nxt         = fl_rdata;
        fl_head_nxt[k_r] = fl_head_r[k_r] + PW'(1);
        fl_cnt_nxt[k_r]  = fl_cnt_r[k_r] - CW'(1);
        state_nxt        = S_SPLIT;
      end
      S_SPLIT: begin
        if (k_r > want_r) begin
          // Upper half of the split goes to the tail of the next lower list.
          if (fl_cnt_r[kd] != CW'(bpa_pkg::TOTAL_PAGES)) begin
            fl_we          = 1'b1;
            fl_waddr       = {kd, fl_head_r[kd] + fl_cnt_r[kd][PW-1:0]};
            fl_wdata       = page_r + (PW'(1) << kd);
            fl_cnt_nxt[kd] = fl_cnt_r[kd] + CW'(1);
          end
          k_nxt = kd;
        end else begin
          rec_we          = 1'b1;
          rec_waddr       = rec_cnt_r[RA-1:0];
          rec_wdata.start = page_r;
          rec_wdata.order = want_r;
          rec_cnt_nxt     = rec_cnt_r + RC'(1);
          res_st_nxt      = bpa_pkg::ST_OK;
          res_page_nxt    = page_r;
          res_ord_nxt     = want_r;
          state_nxt       = S_RESP;
        end
      end
      S_RSCAN: begin
        if (rec_rdata.start == fpage_r) begin
          ord_nxt   = rec_rdata.order;
          rec_raddr = RA'(rec_cnt_r - RC'(1));
          state_nxt = S_RMOVE;
        end else if ({1'b0, i_r} + RC'(1) < rec_cnt_r) begin
          i_nxt     = i_r + RA'(1);
          rec_raddr = i_r + RA'(1);
        end else begin
          res_st_nxt   = bpa_pkg::ST_NOT_FOUND;
          res_page_nxt = '0;
          res_ord_nxt  = '0;
          state_nxt    = S_RESP;
        end
      end
      S_RMOVE: begin
        // The last record fills the vacated slot.
        rec_we       = 1'b1;
        rec_waddr    = i_r;
        rec_wdata    = rec_rdata;
        rec_cnt_nxt  = rec_cnt_r - RC'(1);
        res_st_nxt   = bpa_pkg::ST_OK;
        res_page_nxt = fpage_r;
        res_ord_nxt  = ord_r;
        s_nxt        = fpage_r;
        state_nxt    = S_MCHK;
      end
      S_MCHK: begin
        if (ord_r < OW'(bpa_pkg::MAX_ORDER) && fl_cnt_r[ord_r] != '0) begin
          j_nxt     = '0;
          fl_raddr  = {ord_r, fl_head_r[ord_r]};
          state_nxt = S_MSCAN;
        end else begin
          if (fl_cnt_r[ord_r] != CW'(bpa_pkg::TOTAL_PAGES)) begin
            fl_we             = 1'b1;
            fl_waddr          = {ord_r, fl_head_r[ord_r] + fl_cnt_r[ord_r][PW-1:0]};
            fl_wdata          = s_r;
            fl_cnt_nxt[ord_r] = fl_cnt_r[ord_r] + CW'(1);
          end
          state_nxt = S_RESP;
        end
      end
      S_MSCAN: begin
        if (fl_rdata == buddy) begin
          fl_raddr  = {ord_r, fl_head_r[ord_r] + fl_cnt_r[ord_r][PW-1:0] - PW'(1)};
          state_nxt = S_MREPL;
        end else if ({1'b0, j_r} + CW'(1) < fl_cnt_r[ord_r]) begin
          j_nxt    = j_r + PW'(1);
          fl_raddr = {ord_r, fl_head_r[ord_r] + j_r + PW'(1)};
        end else begin
          if (fl_cnt_r[ord_r] != CW'(bpa_pkg::TOTAL_PAGES)) begin
            fl_we             = 1'b1;
            fl_waddr          = {ord_r, fl_head_r[ord_r] + fl_cnt_r[ord_r][PW-1:0]};
            fl_wdata          = s_r;
            fl_cnt_nxt[ord_r] = fl_cnt_r[ord_r] + CW'(1);
          end
          state_nxt = S_RESP;
        end
      end
      S_MREPL: begin
        // Buddy found: its slot takes the list's last entry, then climb.
        fl_we             = 1'b1;
        fl_waddr          = {ord_r, fl_head_r[ord_r] + j_r};
        fl_wdata          = fl_rdata;
        fl_cnt_nxt[ord_r] = fl_cnt_r[ord_r] - CW'(1);
        s_nxt             = s_r & ~(PW'(1) << ord_r);
        ord_nxt           = ord_r + OW'(1);
        state_nxt         = S_MCHK;
      end
      S_RESP: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // While reset is held, the top-order list receives its single entry,
    // the whole memory as one block at page 0.
    if (!rst_n) begin
      fl_we    = 1'b1;
      fl_waddr = {OW'(bpa_pkg::MAX_ORDER), PW'(0)};
      fl_wdata = '0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    out_st_nxt    = out_st_r;
    out_page_nxt  = out_page_r;
    out_ord_nxt   = out_ord_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_st_nxt    = res_st_r;
      out_page_nxt  = res_page_r;
      out_ord_nxt   = res_ord_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rec_cnt_r   <= '0;
      out_valid_r <= 1'b0;
      for (int o = 0; o < bpa_pkg::NORD; o++) begin
        fl_head_r[o] <= '0;
        fl_cnt_r[o]  <= (o == bpa_pkg::MAX_ORDER) ? CW'(1) : '0;
      end
    end else begin
      state_r     <= state_nxt;
      rec_cnt_r   <= rec_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      fl_head_r   <= fl_head_nxt;
      fl_cnt_r    <= fl_cnt_nxt;
    end
  end

  // Working registers of the sequencer; each is loaded before it is read.
  always_ff @(posedge clk) begin
    func_r     <= func_nxt;
    bytes_r    <= bytes_nxt;
    fpage_r    <= fpage_nxt;
    want_r     <= want_nxt;
    k_r        <= k_nxt;
    page_r     <= (!rst_n) ? '0 : page_nxt;
    ord_r      <= ord_nxt;
    s_r        <= s_nxt;
    i_r        <= i_nxt;
    j_r        <= j_nxt;
    res_st_r   <= res_st_nxt;
    res_page_r <= res_page_nxt;
    res_ord_r  <= res_ord_nxt;
    out_st_r   <= out_st_nxt;
    out_page_r <= out_page_nxt;
    out_ord_r  <= out_ord_nxt;
  end

  a_rec_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rec_cnt_r <= RC'(bpa_pkg::RECORD_SLOTS))
    else $error("record count exceeds table size");

  a_split_order: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SPLIT |-> k_r >= want_r)
    else $error("split went below wanted order");

  a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_MSCAN |-> {1'b0, j_r} < fl_cnt_r[ord_r])
    else $error("free-list scan past its fill count");

  a_alloc_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SPLIT && k_r == want_r) |=> rec_cnt_r == $past(rec_cnt_r) + RC'(1))
    else $error("granted allocation not recorded");
endmodule
`default_nettype wire

@@ sim/buddy_page_allocator_core_tb.sv @@
// Self-checking testbench for the buddy page allocator core.
`default_nettype none
module buddy_page_allocator_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic FN_ALLOC = 1'b0;
  localparam logic FN_FREE  = 1'b1;
  localparam int   QUIET_LIMIT = 20000;
  localparam int   RANDOM_REQS = 1550;
  localparam int   BW = bpa_pkg::BYTES_W;
  localparam int   PW = bpa_pkg::PAGE_W;
  localparam int   OW = bpa_pkg::ORD_W;
  localparam int   SW = bpa_pkg::ST_W;

  typedef struct packed {
    logic          func;
    logic [BW-1:0] bytes;
    logic [PW-1:0] page;
  } req_t;

  typedef struct packed {
    logic [SW-1:0] status;
    logic [PW-1:0] page;
    logic [OW-1:0] order;
  } grant_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_func = 1'b0;
  logic [BW-1:0] in_request_bytes = '0;
  logic [PW-1:0] in_free_start_page = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [SW-1:0] out_status;
  logic [PW-1:0] out_start_page;
  logic [OW-1:0] out_block_order;

  buddy_page_allocator_core uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_func(in_func),
    .in_request_bytes(in_request_bytes), .in_free_start_page(in_free_start_page),
    .out_valid(out_valid), .out_stall(out_stall), .out_status(out_status),
    .out_start_page(out_start_page), .out_block_order(out_block_order)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Predictor state: one FIFO of free starts per order, plus the packed
  // table of outstanding grants.
  int unsigned free_pages[bpa_pkg::NORD][$];
  int unsigned held_start[$];
  int unsigned held_order[$];

  req_t        pending_reqs[$];
  grant_t      expected_grants[$];
  int unsigned live_pages[$];
  int          errors = 0;
  int          quiet_cycles = 0;
  bit          no_idle = 1'b0;

  function automatic bit take_page(int unsigned ord, int unsigned pg);
    for (int i = 0; i < free_pages[ord].size(); i++) begin
      if (free_pages[ord][i] == pg) begin
        // A middle entry is replaced by the last one.
        free_pages[ord][i] = free_pages[ord][free_pages[ord].size() - 1];
        void'(free_pages[ord].pop_back());
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic grant_t predict_grant(req_t r);
    grant_t g;
    int unsigned want;
    int unsigned k;
    int unsigned pg;
    int unsigned ord;
    int idx;
    logic [63:0] b;
    g = '0;
    if (r.func == FN_ALLOC) begin
      b = 64'(r.bytes);
      want = 0;
      while (want <= bpa_pkg::MAX_ORDER &&
             b > (64'd1 << (want + bpa_pkg::PAGE_BYTES_LOG2))) want++;
      if (want > bpa_pkg::MAX_ORDER) begin
        g.status = bpa_pkg::ST_TOO_LARGE;
        return g;
      end
      if (held_start.size() >= bpa_pkg::RECORD_SLOTS) begin
        g.status = bpa_pkg::ST_TABLE_FULL;
        return g;
      end
      k = want;
      while (k <= bpa_pkg::MAX_ORDER && free_pages[k].size() == 0) k++;
      if (k > bpa_pkg::MAX_ORDER) begin
        g.status = bpa_pkg::ST_NO_MEMORY;
        return g;
      end
      pg = free_pages[k].pop_front();
      while (k > want) begin
        k--;
        free_pages[k].push_back(pg + (1 << k));
      end
      held_start.push_back(pg);
      held_order.push_back(want);
      g.status = bpa_pkg::ST_OK;
      g.page = PW'(pg);
      g.order = OW'(want);
    end else begin
      idx = -1;
      for (int i = 0; i < held_start.size(); i++) begin
        if (held_start[i] == r.page) begin
          idx = i;
          break;
        end
      end
      if (idx < 0) begin
        g.status = bpa_pkg::ST_NOT_FOUND;
        return g;
      end
      ord = held_order[idx];
      held_start[idx] = held_start[held_start.size() - 1];
      held_order[idx] = held_order[held_order.size() - 1];
      void'(held_start.pop_back());
      void'(held_order.pop_back());
      g.status = bpa_pkg::ST_OK;
      g.page = r.page;
      g.order = OW'(ord);
      pg = r.page;
      while (ord < bpa_pkg::MAX_ORDER && take_page(ord, pg ^ (1 << ord))) begin
        pg &= ~(1 << ord);
        ord++;
      end
      free_pages[ord].push_back(pg);
    end
    return g;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("ERROR %0t: %s got %0d expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  task automatic queue_alloc(int unsigned nbytes);
    req_t r;
    r = '0;
    r.func = FN_ALLOC;
    r.bytes = BW'(nbytes);
    r.page = PW'($urandom);
    pending_reqs.push_back(r);
  endtask

  task automatic queue_free(int unsigned pg);
    req_t r;
    r = '0;
    r.func = FN_FREE;
    r.page = PW'(pg);
    r.bytes = BW'($urandom);
    pending_reqs.push_back(r);
  endtask

  // Waits for every queued request to be accepted and answered.
  task automatic wait_drained();
    while (pending_reqs.size() > 0 || in_valid || expected_grants.size() > 0)
      @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // Byte count biased to small orders, sometimes any size at all.
  function automatic int unsigned random_bytes();
    int unsigned o;
    if ($urandom_range(0, 19) == 0) return $urandom_range(0, (1 << BW) - 1);
    o = $urandom_range(0, 99) < 80 ? $urandom_range(0, 3)
                                   : $urandom_range(0, bpa_pkg::MAX_ORDER);
    return $urandom_range(0, 1 << (o + bpa_pkg::PAGE_BYTES_LOG2));
  endfunction

  // Driver: the valid stays up while the request is stalled, and a new
  // request may follow in the same edge without a low pulse.
  always @(posedge clk) begin
    req_t nxt;
    if (rst_n) begin
      if (!in_valid || !in_stall) begin
        if (pending_reqs.size() > 0 && (no_idle || $urandom_range(0, 99) >= 33)) begin
          nxt = pending_reqs.pop_front();
          in_valid <= 1'b1;
          in_func <= nxt.func;
          in_request_bytes <= nxt.bytes;
          in_free_start_page <= nxt.page;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= no_idle ? 1'b0 : ($urandom_range(0, 99) < 33);
    end
  end

  // Monitor: the predictor runs at the accepting edge of each request, and
  // results are checked in order at their accepting edges.
  always @(posedge clk) begin
    req_t   acc;
    grant_t g;
    grant_t w;
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (in_valid && !in_stall) begin
        acc.func = in_func;
        acc.bytes = in_request_bytes;
        acc.page = in_free_start_page;
        g = predict_grant(acc);
        expected_grants.push_back(g);
        if (acc.func == FN_ALLOC && g.status == bpa_pkg::ST_OK)
          live_pages.push_back(int'(g.page));
      end
      if (out_valid && !out_stall) begin
        if (expected_grants.size() == 0) begin
          report_mismatch("unexpected result, status", int'(out_status), 0);
        end else begin
          w = expected_grants.pop_front();
          if (out_status !== w.status)
            report_mismatch("status", int'(out_status), int'(w.status));
          if (out_start_page !== w.page)
            report_mismatch("start_page", int'(out_start_page), int'(w.page));
          if (out_block_order !== w.order)
            report_mismatch("block_order", int'(out_block_order), int'(w.order));
        end
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
  end

  // The stimulus and end-of-run sequence live in one process.
  initial begin
    int unsigned pick;
    free_pages[bpa_pkg::MAX_ORDER].push_back(0);
    @(posedge rst_n);
    // Directed: extremes of size, errors, merge of all orders.
    queue_free(0);
    queue_alloc(0);
    queue_alloc(1);
    queue_alloc(4096);
    queue_alloc(4097);
    queue_alloc((1 << BW) - 1);
    queue_alloc(4194304);
    queue_alloc(4194305);
    queue_free(0);
    queue_free(1);
    queue_free(2);
    queue_free(4);
    queue_free(1023);
    queue_alloc(4194304);
    queue_alloc(1);
    queue_free(0);
    queue_alloc(2097152);
    queue_alloc(2097152);
    queue_alloc(2097152);
    queue_free(512);
    queue_free(0);
    wait_drained();
    // Fill the record table with single pages, then one more.
    for (int i = 0; i < bpa_pkg::RECORD_SLOTS + 1; i++) queue_alloc(4096);
    for (int i = 0; i < bpa_pkg::RECORD_SLOTS; i++) queue_free(i);
    wait_drained();
    live_pages.delete();
    // Random part: allocations and frees of live grants, some stray frees.
    for (int n = 0; n < RANDOM_REQS; n++) begin
      while (pending_reqs.size() >= 2) @(posedge clk);
      if (n == 700) wait_drained();
      no_idle = (n >= 300 && n < 500);
      if ($urandom_range(0, 99) < 50 || live_pages.size() == 0) begin
        queue_alloc(random_bytes());
      end else if ($urandom_range(0, 9) == 0) begin
        queue_free($urandom_range(0, bpa_pkg::TOTAL_PAGES - 1));
      end else begin
        pick = $urandom_range(0, live_pages.size() - 1);
        queue_free(live_pages[pick]);
        live_pages.delete(pick);
      end
    end
    no_idle = 1'b0;
    wait_drained();
    repeat (200) @(posedge clk);
    if (errors == 0 && expected_grants.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire
